// File: rtl/core/scancode_to_ascii_fifo_assert.svh
// Assertion macros for the scan code translator.
// Included by the top level; no other dependencies.
`ifndef SCANCODE_TO_ASCII_FIFO_ASSERT_SVH
`define SCANCODE_TO_ASCII_FIFO_ASSERT_SVH
`ifndef SYNTHESIS
`define STA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sta assertion failed");
`define STA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sta assertion failed");
`else
`define STA_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define STA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/core/sta_pkg.sv
// Shared types, key tables and FIFO sizing for the scan code translator.
// No dependencies; used by every module of the block but sta_ram.
`default_nettype none

package sta_pkg;

    // Character FIFO sizing (ring of FIFO_DEPTH slots, FIFO_DEPTH-1 usable)
    localparam int FIFO_DEPTH = 256;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);

    typedef logic [PTR_W-1:0] ptr_t;

    // Request and response payloads
    typedef struct packed {
        logic       req_type;
        logic [7:0] scan_code;
    } req_t;

    typedef struct packed {
        logic [6:0] char_out;
        logic       char_valid;
        logic       has_input;
        logic       dropped;
    } rsp_t;

    // Request kinds
    localparam logic REQ_SCAN = 1'b0;
    localparam logic REQ_POP  = 1'b1;

    // Classified operation handed from front to back
    typedef struct packed {
        logic       is_pop;
        logic       is_push;
        logic [6:0] ch;
    } op_t;

    // Modifier key codes (set 1, press form)
    localparam logic [6:0] KEY_LSHIFT = 7'h2A;
    localparam logic [6:0] KEY_RSHIFT = 7'h36;
    localparam logic [6:0] KEY_CTRL   = 7'h1D;
    localparam logic [6:0] KEY_ALT    = 7'h38;
    localparam logic [6:0] KEY_CAPS   = 7'h3A;

    // Codes below this value have a table entry
    localparam logic [7:0] KEY_TABLE_LEN = 8'd58;

    // Letter bounds and case offsets
    localparam logic [6:0] CHR_LO_A   = 7'h61;
    localparam logic [6:0] CHR_LO_Z   = 7'h7A;
    localparam logic [6:0] CHR_UP_A   = 7'h41;
    localparam logic [6:0] CHR_UP_Z   = 7'h5A;
    localparam logic [6:0] CASE_DELTA = 7'h20;
    localparam logic [6:0] CTRL_LO    = 7'h60;
    localparam logic [6:0] CTRL_UP    = 7'h40;

    // Key tables, padded with zeros to a full 6-bit index
    localparam logic [6:0] KEY_PLAIN [64] = '{
        7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
        7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
        7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
        7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00, 7'h61, 7'h73,
        7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
        7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
        7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A,
        7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
    };

    localparam logic [6:0] KEY_SHIFTED [64] = '{
        7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
        7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09,
        7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
        7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00, 7'h41, 7'h53,
        7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
        7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
        7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A,
        7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
    };

    // Advance a ring pointer, wrapping at FIFO_DEPTH
    function automatic ptr_t ptr_inc(input ptr_t p);
        ptr_t r;
        if (p == ptr_t'(FIFO_DEPTH - 1))
            r = '0;
        else
            r = p + ptr_t'(1);
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/sta_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module sta_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port: hold data when not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/sta_front.sv
// Front end: accepts requests, tracks modifier keys, translates scan codes.
// Depends on sta_pkg for request, operation types and key tables.
`default_nettype none

module sta_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    input  wire sta_pkg::req_t req,
    input  wire logic          q_full,
    output logic               req_stall,
    output logic               op_valid,
    output sta_pkg::op_t       op
);

    logic       shift_reg, shift_next;
    logic       ctrl_reg,  ctrl_next;
    logic       caps_reg,  caps_next;
    logic       accept;
    logic       is_scan;
    logic       release_key;
    logic [6:0] key;
    logic       key_shift, key_ctrl, key_alt, key_caps, key_mod;
    logic       in_table;
    logic [6:0] raw_ch, caps_ch, ctrl_ch;

    assign req_stall = q_full;
    assign accept    = req_valid && !q_full;
    assign op_valid  = req_valid;

    // Decode the scan byte
    assign is_scan     = (req.req_type == sta_pkg::REQ_SCAN);
    assign release_key = req.scan_code[7];
    assign key         = req.scan_code[6:0];
    assign key_shift   = (key == sta_pkg::KEY_LSHIFT) || (key == sta_pkg::KEY_RSHIFT);
    assign key_ctrl    = (key == sta_pkg::KEY_CTRL);
    assign key_alt     = (key == sta_pkg::KEY_ALT);
    assign key_caps    = (key == sta_pkg::KEY_CAPS);
    assign key_mod     = key_shift || key_ctrl || key_alt || key_caps;
    assign in_table    = (req.scan_code < sta_pkg::KEY_TABLE_LEN);

    // Look up the character and apply caps lock, then ctrl
    always_comb
    begin
        raw_ch = shift_reg ? sta_pkg::KEY_SHIFTED[req.scan_code[5:0]]
                           : sta_pkg::KEY_PLAIN[req.scan_code[5:0]];

        caps_ch = raw_ch;
        if (caps_reg)
        begin
            if (raw_ch >= sta_pkg::CHR_LO_A && raw_ch <= sta_pkg::CHR_LO_Z)
                caps_ch = raw_ch - sta_pkg::CASE_DELTA;
            else if (raw_ch >= sta_pkg::CHR_UP_A && raw_ch <= sta_pkg::CHR_UP_Z)
                caps_ch = raw_ch + sta_pkg::CASE_DELTA;
        end

        ctrl_ch = caps_ch;
        if (ctrl_reg)
        begin
            if (caps_ch >= sta_pkg::CHR_LO_A && caps_ch <= sta_pkg::CHR_LO_Z)
                ctrl_ch = caps_ch - sta_pkg::CTRL_LO;
            else if (caps_ch >= sta_pkg::CHR_UP_A && caps_ch <= sta_pkg::CHR_UP_Z)
                ctrl_ch = caps_ch - sta_pkg::CTRL_UP;
        end
    end

    // Classify the request for the back end
    always_comb
    begin
        op.is_pop  = (req.req_type == sta_pkg::REQ_POP);
        op.is_push = is_scan && !release_key && !key_mod && in_table && (ctrl_ch != 7'd0);
        op.ch      = ctrl_ch;
    end

    // Update held modifiers; alt press and release carry no character
    always_comb
    begin
        shift_next = shift_reg;
        ctrl_next  = ctrl_reg;
        caps_next  = caps_reg;
        if (accept && is_scan)
        begin
            if (release_key)
            begin
                if (key_shift)
                    shift_next = 1'b0;
                if (key_ctrl)
                    ctrl_next = 1'b0;
            end
            else
            begin
                if (key_shift)
                    shift_next = 1'b1;
                if (key_ctrl)
                    ctrl_next = 1'b1;
                if (key_caps)
                    caps_next = !caps_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg <= 1'b0;
            ctrl_reg  <= 1'b0;
            caps_reg  <= 1'b0;
        end
        else
        begin
            shift_reg <= shift_next;
            ctrl_reg  <= ctrl_next;
            caps_reg  <= caps_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/sta_queue.sv
// Two-entry operation queue between front and back ends.
// Depends on sta_pkg for the operation type.
`default_nettype none

module sta_queue (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push_valid,
    input  wire sta_pkg::op_t push_op,
    output logic              full,
    output logic              pop_valid,
    output sta_pkg::op_t      pop_op,
    input  wire logic         pop_take
);

    sta_pkg::op_t q_reg [2];
    logic         wr_reg, wr_next;
    logic         rd_reg, rd_next;
    logic [1:0]   count_reg, count_next;
    logic         do_push;

    assign full      = (count_reg == 2'd2);
    assign pop_valid = (count_reg != 2'd0);
    assign pop_op    = q_reg[rd_reg];
    assign do_push   = push_valid && !full;

    // Advance pointers and occupancy
    always_comb
    begin
        wr_next    = wr_reg;
        rd_next    = rd_reg;
        count_next = count_reg;
        if (do_push)
            wr_next = !wr_reg;
        if (pop_take)
            rd_next = !rd_reg;
        if (do_push && !pop_take)
            count_next = count_reg + 2'd1;
        else if (!do_push && pop_take)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= 1'b0;
            rd_reg    <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

    // Hold entries
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_reg] <= push_op;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/sta_back.sv
// Back end: character FIFO push and pop, response register.
// Depends on sta_pkg and sta_ram.
`default_nettype none

module sta_back (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         op_valid,
    input  wire sta_pkg::op_t op,
    output logic              op_take,
    output logic              rsp_valid,
    input  wire logic         rsp_stall,
    output sta_pkg::rsp_t     rsp
);

    sta_pkg::ptr_t wr_ptr_reg, wr_ptr_next;
    sta_pkg::ptr_t rd_ptr_reg, rd_ptr_next;
    sta_pkg::ptr_t wr_inc;
    logic          valid_reg;
    logic          hit_reg, hit_next;
    logic          has_reg, has_next;
    logic          drop_reg, drop_next;
    logic          advance;
    logic          empty, full;
    logic          push_ok;
    logic [6:0]    rdata;

    // Advance when the response register is free or being taken
    assign advance = !valid_reg || !rsp_stall;
    assign op_take = op_valid && advance;

    assign wr_inc = sta_pkg::ptr_inc(wr_ptr_reg);
    assign empty  = (wr_ptr_reg == rd_ptr_reg);
    assign full   = (wr_inc == rd_ptr_reg);

    // Carry out the operation
    always_comb
    begin
        hit_next    = op_take && op.is_pop && !empty;
        push_ok     = op_take && op.is_push && !full;
        drop_next   = op_take && op.is_push && full;
        wr_ptr_next = push_ok ? wr_inc : wr_ptr_reg;
        rd_ptr_next = hit_next ? sta_pkg::ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        has_next    = (wr_ptr_next != rd_ptr_next);
    end

    sta_ram #(
        .WIDTH (7),
        .DEPTH (sta_pkg::FIFO_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (push_ok),
        .waddr (wr_ptr_reg),
        .wdata (op.ch),
        .re    (hit_next),
        .raddr (rd_ptr_reg),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            valid_reg  <= 1'b0;
            hit_reg    <= 1'b0;
            has_reg    <= 1'b0;
            drop_reg   <= 1'b0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            if (advance)
            begin
                valid_reg <= op_take;
                hit_reg   <= hit_next;
                has_reg   <= has_next;
                drop_reg  <= drop_next;
            end
        end
    end

    // Drive the response; read data holds while stalled
    assign rsp_valid      = valid_reg;
    assign rsp.char_out   = hit_reg ? rdata : 7'd0;
    assign rsp.char_valid = hit_reg;
    assign rsp.has_input  = has_reg;
    assign rsp.dropped    = drop_reg;

endmodule

`default_nettype wire

// File: rtl/core/scancode_to_ascii_fifo.sv
// Top level of the scan code to ASCII translator with character FIFO.
// Depends on sta_pkg, sta_front, sta_queue, sta_back and the assertion header.
//
//   Channel | Signals                      | Payload
//   --------+------------------------------+-------------------------------
//   request | req_valid, req_stall, req    | req_type, scan_code
//   response| rsp_valid, rsp_stall, rsp    | char_out, char_valid, has_input,
//           |                              | dropped
//
// One request per cycle while the queue is not full; a taken request is written
// into the queue, then into the response register, which presents its response.
// The FIFO RAM read is registered on the same edge as the response register.
// Reset clears modifiers, the queue, the FIFO pointers; the RAM is not cleared.
// A stalled response holds the back end; the two-entry queue absorbs the
// front, which stalls requests only when the queue is full.
`default_nettype none
`include "scancode_to_ascii_fifo_assert.svh"

module scancode_to_ascii_fifo (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_stall,
    input  wire sta_pkg::req_t req,
    output logic               rsp_valid,
    input  wire logic          rsp_stall,
    output sta_pkg::rsp_t      rsp
);

    logic         f_valid;
    sta_pkg::op_t f_op;
    logic         q_full;
    logic         q_valid;
    sta_pkg::op_t q_op;
    logic         q_take;

    sta_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req       (req),
        .q_full    (q_full),
        .req_stall (req_stall),
        .op_valid  (f_valid),
        .op        (f_op)
    );

    sta_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_op    (f_op),
        .full       (q_full),
        .pop_valid  (q_valid),
        .pop_op     (q_op),
        .pop_take   (q_take)
    );

    sta_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (q_valid),
        .op        (q_op),
        .op_take   (q_take),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // A popped character was pushed nonzero
    `STA_ASSERT_NOW(a_char_nonzero, clk, rst_n, rsp_valid && rsp.char_valid, rsp.char_out != 7'd0)
    // A drop means the FIFO was full, so it still holds characters
    `STA_ASSERT_NOW(a_drop_nonempty, clk, rst_n, rsp_valid && rsp.dropped, rsp.has_input)
    // A response is never both a pop hit and a drop
    `STA_ASSERT_NOW(a_hit_xor_drop, clk, rst_n, rsp_valid, !(rsp.char_valid && rsp.dropped))
    // A queued operation with a free response register is taken at once
    `STA_ASSERT_NEXT(a_queue_take, clk, rst_n, q_valid && !rsp_valid, rsp_valid)

endmodule

`default_nettype wire
